// ===== design/page_frame_bitmap_allocator_macros.svh =====
// assertion macros for the page frame allocator
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define PFBA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfba assertion failed");

// next-cycle implication
`define PFBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfba assertion failed");

`endif

// ===== design/pfba_pkg.sv =====
package pfba_pkg;

   // geometry
   localparam int NUM_PAGES  = 32768;
   localparam int PAGE_SHIFT = 12;
   localparam int WORD_BITS  = 32;
   localparam int MAP_WORDS  = 1024;
   localparam int WADDR_W    = 10;

   // op codes
   localparam logic [2:0] OP_ALLOC_LOW  = 3'd0;
   localparam logic [2:0] OP_ALLOC_HIGH = 3'd1;
   localparam logic [2:0] OP_ALLOC_AREA = 3'd2;
   localparam logic [2:0] OP_FREE       = 3'd3;
   localparam logic [2:0] OP_MARK_FREE  = 3'd4;
   localparam logic [2:0] OP_MARK_USED  = 3'd5;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_SPACE = 2'd1;
   localparam logic [1:0] ST_RANGE    = 2'd2;

   // register indexes
   localparam logic CSR_LOW_BASE  = 1'b0;
   localparam logic CSR_LOW_LIMIT = 1'b1;

   // datapath actions
   localparam logic [3:0] ACT_NONE    = 4'd0;
   localparam logic [3:0] ACT_LOAD    = 4'd1;
   localparam logic [3:0] ACT_FREE    = 4'd2;
   localparam logic [3:0] ACT_PG_FAIL = 4'd3;
   localparam logic [3:0] ACT_PG_USE  = 4'd4;
   localparam logic [3:0] ACT_AR_FAIL = 4'd5;
   localparam logic [3:0] ACT_AR_BIT  = 4'd6;
   localparam logic [3:0] ACT_RG_WR   = 4'd7;
   localparam logic [3:0] ACT_CLR     = 4'd8;

   typedef struct packed {
      logic [3:0]         act;
      logic               ram_rd;
      logic [WADDR_W-1:0] clr_addr;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       cur_ge_end;
      logic       cur_ge_last;
      logic       need_zero;
      logic       pg_found;
      logic       ar_hit;
      logic       ar_fail;
      logic       ar_cross;
   } stat_type;

   // lowest set bit of a word
   function automatic logic [4:0] first_set(input logic [WORD_BITS-1:0] v);
      logic [4:0] r;
      r = 5'd0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) r = 5'(i);
      end
      return r;
   endfunction

endpackage

// ===== design/pfba_if.sv =====
// request channel
interface pfba_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [26:0] address;
   logic [27:0] size_bytes;
   modport source (output valid, op, address, size_bytes, input ready);
   modport sink (input valid, op, address, size_bytes, output ready);
endinterface

// response channel
interface pfba_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [26:0] result_address;
   modport source (output valid, status, result_address, input ready);
   modport sink (input valid, status, result_address, output ready);
endinterface

// register write channel
interface pfba_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== design/pfba_ram.sv =====
module pfba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== design/pfba_dp.sv =====
module pfba_dp (
   input  logic               clock,
   input  logic               reset,
   input  pfba_pkg::cmd_type  cmd,
   output pfba_pkg::stat_type stat,
   input  logic [2:0]         req_op,
   input  logic [26:0]        req_address,
   input  logic [27:0]        req_size,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [15:0]        csr_data,
   output logic [1:0]         status,
   output logic [26:0]        result_address
);
   logic [14:0] base_ff, base_in;
   logic [15:0] limit_ff, limit_in;
   logic [15:0] low_hint_ff, low_hint_in;
   logic [15:0] high_hint_ff, high_hint_in;
   logic [2:0]  op_ff, op_in;
   logic [16:0] cur_ff, cur_in;
   logic [16:0] last_ff, last_in;
   logic [15:0] end_ff, end_in;
   logic [15:0] start_ff, start_in;
   logic [16:0] run_ff, run_in;
   logic [16:0] need_ff, need_in;
   logic        set_ff, set_in;
   logic [1:0]  status_ff, status_in;
   logic [26:0] result_ff, result_in;

   logic                      ram_we;
   logic [pfba_pkg::WADDR_W-1:0] ram_waddr;
   logic [31:0]               ram_wdata, rdata;

   logic [15:0] low_end;
   logic        same_end, same_last;
   logic [31:0] lo_mask, end_mask, hi_mask, free_bits, rg_mask, rg_wdata;
   logic [4:0]  pg_bit;
   logic [14:0] pg_page;
   logic [16:0] pg_adv, pg_next, cur_n1, word_next;
   logic        ar_used, ar_hit;
   logic [16:0] run_n;
   logic [15:0] start_n;
   logic [16:0] ld_page, ld_last;
   logic [28:0] ld_sum;
   logic        ld_over;

   pfba_ram #(.WIDTH(pfba_pkg::WORD_BITS), .DEPTH(pfba_pkg::MAP_WORDS)) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (cmd.ram_rd),
      .raddr (cur_ff[14:5]),
      .rdata (rdata)
   );

   // arena end and word masks
   assign low_end   = (limit_ff < 16'(pfba_pkg::NUM_PAGES)) ? limit_ff
                                                          : 16'(pfba_pkg::NUM_PAGES);
   assign same_end  = ({1'b0, end_ff[15:5]} == cur_ff[16:5]);
   assign same_last = (last_ff[16:5] == cur_ff[16:5]);
   assign lo_mask   = 32'hFFFF_FFFF << cur_ff[4:0];
   assign end_mask  = same_end ? ((32'h1 << end_ff[4:0]) - 32'h1) : 32'hFFFF_FFFF;
   assign hi_mask   = same_last ? ((32'h1 << last_ff[4:0]) - 32'h1) : 32'hFFFF_FFFF;
   assign word_next = {cur_ff[16:5] + 12'd1, 5'd0};

   // single page search within the fetched word
   assign free_bits = ~rdata & lo_mask & end_mask;
   assign pg_bit    = pfba_pkg::first_set(free_bits);
   assign pg_page   = {cur_ff[14:5], pg_bit};
   assign pg_adv    = word_next;
   assign pg_next   = (pg_adv > {1'b0, end_ff}) ? {1'b0, end_ff} : pg_adv;

   // area run tracking, one page a cycle while no new map word is being fetched
   assign ar_used = rdata[cur_ff[4:0]];
   assign run_n   = ar_used ? 17'd0 : run_ff + 17'd1;
   assign start_n = ar_used ? cur_ff[15:0] + 16'd1 : start_ff;
   assign ar_hit  = (run_n >= need_ff);
   assign cur_n1  = cur_ff + 17'd1;

   // range update of one word
   assign rg_mask  = lo_mask & hi_mask;
   assign rg_wdata = set_ff ? (rdata | rg_mask) : (rdata & ~rg_mask);

   // request decode
   assign ld_page = {2'b00, req_address[26:12]};
   assign ld_sum  = {2'b00, req_address} + {1'b0, req_size};
   assign ld_last = ld_sum[28:12];
   assign ld_over = (ld_last > 17'(pfba_pkg::NUM_PAGES));

   assign stat.op          = op_ff;
   assign stat.cur_ge_end  = (cur_ff >= {1'b0, end_ff});
   assign stat.cur_ge_last = (cur_ff >= last_ff);
   assign stat.need_zero   = (need_ff == 17'd0);
   assign stat.pg_found    = |free_bits;
   assign stat.ar_hit      = ar_hit;
   assign stat.ar_fail     = !ar_hit && (cur_n1 >= {1'b0, end_ff});
   assign stat.ar_cross    = (cur_n1[4:0] == 5'd0);

   // next state of the datapath
   always_comb begin
      base_in      = base_ff;
      limit_in     = limit_ff;
      low_hint_in  = low_hint_ff;
      high_hint_in = high_hint_ff;
      op_in        = op_ff;
      cur_in       = cur_ff;
      last_in      = last_ff;
      end_in       = end_ff;
      start_in     = start_ff;
      run_in       = run_ff;
      need_in      = need_ff;
      set_in       = set_ff;
      status_in    = status_ff;
      result_in    = result_ff;
      ram_we       = 1'b0;
      ram_waddr    = cur_ff[14:5];
      ram_wdata    = rg_wdata;
      case (cmd.act)
         pfba_pkg::ACT_LOAD: begin
            op_in     = req_op;
            status_in = pfba_pkg::ST_OK;
            result_in = 27'd0;
            set_in    = (req_op == pfba_pkg::OP_MARK_USED) ||
                        (req_op == pfba_pkg::OP_ALLOC_AREA);
            need_in   = {1'b0, req_size[27:12]};
            run_in    = 17'd0;
            case (req_op)
               pfba_pkg::OP_ALLOC_LOW: begin
                  cur_in = {1'b0, low_hint_ff};
                  end_in = low_end;
               end
               pfba_pkg::OP_ALLOC_HIGH: begin
                  cur_in = {1'b0, high_hint_ff};
                  end_in = 16'(pfba_pkg::NUM_PAGES);
               end
               pfba_pkg::OP_ALLOC_AREA: begin
                  cur_in   = {1'b0, low_hint_ff};
                  start_in = low_hint_ff;
                  end_in   = low_end;
               end
               pfba_pkg::OP_FREE: begin
                  cur_in  = ld_page;
                  last_in = ld_page + 17'd1;
               end
               pfba_pkg::OP_MARK_FREE, pfba_pkg::OP_MARK_USED: begin
                  cur_in    = ld_page;
                  last_in   = ld_over ? 17'(pfba_pkg::NUM_PAGES) : ld_last;
                  status_in = ld_over ? pfba_pkg::ST_RANGE : pfba_pkg::ST_OK;
               end
               default: begin
               end
            endcase
         end
         pfba_pkg::ACT_FREE: begin
            if (cur_ff[15:0] < limit_ff) begin
               if (cur_ff[15:0] < low_hint_ff) low_hint_in = cur_ff[15:0];
            end else if (cur_ff[15:0] < high_hint_ff) begin
               high_hint_in = cur_ff[15:0];
            end
         end
         pfba_pkg::ACT_PG_FAIL: begin
            status_in = pfba_pkg::ST_NO_SPACE;
            if (op_ff == pfba_pkg::OP_ALLOC_LOW) low_hint_in = cur_ff[15:0];
            else high_hint_in = cur_ff[15:0];
         end
         pfba_pkg::ACT_PG_USE: begin
            if (|free_bits) begin
               ram_we    = 1'b1;
               ram_wdata = rdata | (32'h1 << pg_bit);
               result_in = {pg_page, 12'd0};
               if (op_ff == pfba_pkg::OP_ALLOC_LOW) low_hint_in = {1'b0, pg_page};
               else high_hint_in = {1'b0, pg_page};
            end else begin
               cur_in = pg_next;
            end
         end
         pfba_pkg::ACT_AR_FAIL: begin
            status_in = pfba_pkg::ST_NO_SPACE;
         end
         pfba_pkg::ACT_AR_BIT: begin
            run_in   = run_n;
            start_in = start_n;
            cur_in   = cur_n1;
            if (ar_hit) begin
               cur_in    = {1'b0, start_n};
               last_in   = {1'b0, start_n} + need_ff;
               result_in = {start_n[14:0], 12'd0};
               if (start_n == low_hint_ff) low_hint_in = low_hint_ff + need_ff[15:0];
            end
         end
         pfba_pkg::ACT_RG_WR: begin
            ram_we = 1'b1;
            cur_in = word_next;
         end
         pfba_pkg::ACT_CLR: begin
            ram_we    = 1'b1;
            ram_waddr = cmd.clr_addr;
            ram_wdata = 32'hFFFF_FFFF;
         end
         default: begin
         end
      endcase
      // register writes must arrive only while idle; the block does not enforce it
      if (csr_we) begin
         if (csr_index == pfba_pkg::CSR_LOW_BASE) begin
            base_in     = csr_data[14:0];
            low_hint_in = {1'b0, csr_data[14:0]};
         end else begin
            limit_in     = csr_data;
            high_hint_in = csr_data;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= 15'd256;
         limit_ff     <= 16'd4096;
         low_hint_ff  <= 16'd256;
         high_hint_ff <= 16'd4096;
      end else begin
         base_ff      <= base_in;
         limit_ff     <= limit_in;
         low_hint_ff  <= low_hint_in;
         high_hint_ff <= high_hint_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      cur_ff    <= cur_in;
      last_ff   <= last_in;
      end_ff    <= end_in;
      start_ff  <= start_in;
      run_ff    <= run_in;
      need_ff   <= need_in;
      set_ff    <= set_in;
      status_ff <= status_in;
      result_ff <= result_in;
   end

   assign status         = status_ff;
   assign result_address = result_ff;
endmodule

// ===== design/pfba_ctrl.sv =====
module pfba_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  pfba_pkg::stat_type stat,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pfba_pkg::cmd_type  cmd
);
   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DISP   = 4'd2;
   localparam logic [3:0] S_PG_CHK = 4'd3;
   localparam logic [3:0] S_PG_RD  = 4'd4;
   localparam logic [3:0] S_PG_USE = 4'd5;
   localparam logic [3:0] S_AR_CHK = 4'd6;
   localparam logic [3:0] S_AR_RD  = 4'd7;
   localparam logic [3:0] S_AR_BIT = 4'd8;
   localparam logic [3:0] S_RG_CHK = 4'd9;
   localparam logic [3:0] S_RG_RD  = 4'd10;
   localparam logic [3:0] S_RG_WR  = 4'd11;
   localparam logic [3:0] S_RESP   = 4'd12;

   logic [3:0]                   state_ff, state_in;
   logic [pfba_pkg::WADDR_W-1:0] clr_ff, clr_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cmd.act      = pfba_pkg::ACT_NONE;
      cmd.ram_rd   = 1'b0;
      cmd.clr_addr = clr_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.act = pfba_pkg::ACT_CLR;
            clr_in  = clr_ff + 1'b1;
            if (&clr_ff) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.act  = pfba_pkg::ACT_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            case (stat.op)
               pfba_pkg::OP_ALLOC_LOW, pfba_pkg::OP_ALLOC_HIGH: state_in = S_PG_CHK;
               pfba_pkg::OP_ALLOC_AREA: state_in = S_AR_CHK;
               pfba_pkg::OP_FREE: begin
                  cmd.act  = pfba_pkg::ACT_FREE;
                  state_in = S_RG_CHK;
               end
               pfba_pkg::OP_MARK_FREE, pfba_pkg::OP_MARK_USED: state_in = S_RG_CHK;
               default: state_in = S_RESP;
            endcase
         end
         S_PG_CHK: begin
            if (stat.cur_ge_end) begin
               cmd.act  = pfba_pkg::ACT_PG_FAIL;
               state_in = S_RESP;
            end else begin
               state_in = S_PG_RD;
            end
         end
         S_PG_RD: begin
            cmd.ram_rd = 1'b1;
            state_in   = S_PG_USE;
         end
         S_PG_USE: begin
            cmd.act  = pfba_pkg::ACT_PG_USE;
            state_in = stat.pg_found ? S_RESP : S_PG_CHK;
         end
         S_AR_CHK: begin
            if (stat.need_zero || stat.cur_ge_end) begin
               cmd.act  = pfba_pkg::ACT_AR_FAIL;
               state_in = S_RESP;
            end else begin
               state_in = S_AR_RD;
            end
         end
         S_AR_RD: begin
            cmd.ram_rd = 1'b1;
            state_in   = S_AR_BIT;
         end
         S_AR_BIT: begin
            if (stat.ar_hit) begin
               cmd.act  = pfba_pkg::ACT_AR_BIT;
               state_in = S_RG_CHK;
            end else if (stat.ar_fail) begin
               cmd.act  = pfba_pkg::ACT_AR_FAIL;
               state_in = S_RESP;
            end else begin
               cmd.act  = pfba_pkg::ACT_AR_BIT;
               state_in = stat.ar_cross ? S_AR_RD : S_AR_BIT;
            end
         end
         S_RG_CHK: begin
            state_in = stat.cur_ge_last ? S_RESP : S_RG_RD;
         end
         S_RG_RD: begin
            cmd.ram_rd = 1'b1;
            state_in   = S_RG_WR;
         end
         S_RG_WR: begin
            cmd.act  = pfba_pkg::ACT_RG_WR;
            state_in = S_RG_CHK;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end
endmodule

// ===== design/page_frame_bitmap_allocator.sv =====
// Bitmap page frame allocator over 32768 pages of 4 KiB, one used bit per page
// held in a 1024 x 32 map memory with one write port and one registered read
// port. After reset the block sweeps all 1024 map words to all-used and takes
// no request until that is done; register writes are taken at any time the
// block is idle. Every request gives exactly one response. Single-page
// allocation reads and scans each map word visited; area allocation fetches
// each word and then examines its pages one at a time, then runs the marking
// pass; free and mark-range read, modify and write each map word touched. The
// time taken is set by the registered read of the map memory, the
// read-modify-write of each map word and the one-page-a-cycle run counter of
// the area search. One request is in flight at a time.
`include "page_frame_bitmap_allocator_macros.svh"

module page_frame_bitmap_allocator (
   input logic clock,
   input logic reset,
   pfba_req_if.sink req_ch,
   pfba_rsp_if.source rsp_ch,
   pfba_csr_if.sink csr_ch
);
   pfba_pkg::cmd_type  cmd;
   pfba_pkg::stat_type stat;
   logic               req_ready, rsp_valid;

   // register port is always open; writes must come only while idle, which the block does not enforce
   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;

   pfba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   pfba_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_op         (req_ch.op),
      .req_address    (req_ch.address),
      .req_size       (req_ch.size_bytes),
      .csr_we         (csr_ch.valid),
      .csr_index      (csr_ch.index),
      .csr_data       (csr_ch.data),
      .status         (rsp_ch.status),
      .result_address (rsp_ch.result_address)
   );

   // checks
   `PFBA_ASSERT_NOW(a_one_in_flight, clock, reset, rsp_valid, !req_ready)
   `PFBA_ASSERT_NEXT(a_beat_once, clock, reset, rsp_valid && rsp_ch.ready, !rsp_valid)
   `PFBA_ASSERT_NOW(a_no_req_in_clear, clock, reset, cmd.act == pfba_pkg::ACT_CLR, !req_ready)
endmodule

// ===== tb/sv/tb_page_frame_bitmap_allocator.sv =====
module tb_page_frame_bitmap_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   // op codes the block treats as no operation
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   localparam int WATCHDOG_CYCLES = 150000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 32;

   typedef struct {
      logic [1:0]  status;
      logic [26:0] addr;
   } alloc_result_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [26:0] address;
      logic [27:0] size;
      logic        fixed;
      logic [1:0]  status;
      logic [26:0] raddr;
   } dir_row_type;

   logic clock;
   logic reset;

   pfba_req_if req_ch();
   pfba_rsp_if rsp_ch();
   pfba_csr_if csr_ch();

   page_frame_bitmap_allocator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // clock
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // shadow of the used map, hints and arena registers
   bit          page_used_sh[pfba_pkg::NUM_PAGES];
   int          low_hint_sh;
   int          high_hint_sh;
   int          arena_base_sh;
   int          arena_limit_sh;

   alloc_result_type pending_results[$];
   int          error_count = 0;
   bit          hold_off_request = 1'b0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
      error_count++;
   endtask

   // next-state and result of one request
   function automatic alloc_result_type predict_alloc(input logic [2:0] op,
                                                      input logic [26:0] address,
                                                      input logic [27:0] size);
      alloc_result_type r;
      int low_end;
      int h;
      int stop;
      int need;
      int start;
      int run;
      int first;
      int last;
      bit found;
      r.status = pfba_pkg::ST_OK;
      r.addr = '0;
      low_end = (arena_limit_sh < pfba_pkg::NUM_PAGES) ? arena_limit_sh
                                                       : pfba_pkg::NUM_PAGES;
      case (op)
         pfba_pkg::OP_ALLOC_LOW, pfba_pkg::OP_ALLOC_HIGH: begin
            h = (op == pfba_pkg::OP_ALLOC_LOW) ? low_hint_sh : high_hint_sh;
            stop = (op == pfba_pkg::OP_ALLOC_LOW) ? low_end : pfba_pkg::NUM_PAGES;
            while (h < stop && page_used_sh[h]) h++;
            if (h < stop) begin
               page_used_sh[h] = 1'b1;
               r.addr = 27'(h << pfba_pkg::PAGE_SHIFT);
            end else begin
               r.status = pfba_pkg::ST_NO_SPACE;
            end
            if (op == pfba_pkg::OP_ALLOC_LOW) low_hint_sh = h;
            else high_hint_sh = h;
         end
         pfba_pkg::OP_ALLOC_AREA: begin
            need = int'(size >> pfba_pkg::PAGE_SHIFT);
            start = low_hint_sh;
            run = 0;
            found = 1'b0;
            if (need != 0) begin
               for (int p = low_hint_sh; p < low_end; p++) begin
                  if (page_used_sh[p]) begin
                     run = 0;
                     start = p + 1;
                  end else begin
                     run++;
                  end
                  if (run >= need) begin
                     found = 1'b1;
                     break;
                  end
               end
            end
            if (found) begin
               for (int k = 0; k < need; k++) page_used_sh[start + k] = 1'b1;
               if (start == low_hint_sh) low_hint_sh += need;
               r.addr = 27'(start << pfba_pkg::PAGE_SHIFT);
            end else begin
               r.status = pfba_pkg::ST_NO_SPACE;
            end
         end
         pfba_pkg::OP_FREE: begin
            h = int'(address >> pfba_pkg::PAGE_SHIFT);
            if (h >= pfba_pkg::NUM_PAGES) begin
               r.status = pfba_pkg::ST_RANGE;
            end else begin
               if (h < arena_limit_sh) begin
                  if (h < low_hint_sh) low_hint_sh = h;
               end else if (h < high_hint_sh) begin
                  high_hint_sh = h;
               end
               page_used_sh[h] = 1'b0;
            end
         end
         pfba_pkg::OP_MARK_FREE, pfba_pkg::OP_MARK_USED: begin
            first = int'(address >> pfba_pkg::PAGE_SHIFT);
            last = (int'(address) + int'(size)) >> pfba_pkg::PAGE_SHIFT;
            if (last > pfba_pkg::NUM_PAGES) begin
               last = pfba_pkg::NUM_PAGES;
               r.status = pfba_pkg::ST_RANGE;
            end
            if (first >= pfba_pkg::NUM_PAGES) r.status = pfba_pkg::ST_RANGE;
            for (int p = first; p < last; p++)
               page_used_sh[p] = (op == pfba_pkg::OP_MARK_USED);
         end
         default: ;
      endcase
      return r;
   endfunction

   // check each response beat against the oldest expectation
   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t response with nothing outstanding", $time);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.status !== want.status)
               report_mismatch("status", rsp_ch.status, want.status);
            if (rsp_ch.result_address !== want.addr)
               report_mismatch("result_address", rsp_ch.result_address, want.addr);
         end
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      int quiet;
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= WATCHDOG_CYCLES) begin
            $display("timeout after %0d idle cycles", quiet);
            $display("** page_frame_bitmap_allocator: FAILED **");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // response side: random stalls and one long hold-off on request
   initial begin
      int stall;
      stall = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_ch.ready <= 1'b0;
            hold_off_request = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (rsp_ch.valid && rsp_ch.ready) stall = pick_gap();
         end
      end
   end

   // one request beat; leaves valid high
   task automatic send_request(input logic [2:0] op, input logic [26:0] address,
                               input logic [27:0] size, input bit fixed = 1'b0,
                               input alloc_result_type fixed_res =
                                  '{pfba_pkg::ST_OK, '0});
      alloc_result_type r;
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.address <= address;
      req_ch.size_bytes <= size;
      do @(posedge clock); while (!req_ch.ready);
      r = predict_alloc(op, address, size);
      pending_results.push_back(fixed ? fixed_res : r);
   endtask

   task automatic sender_gap(input int cycles);
      if (cycles > 0) begin
         req_ch.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   // one register beat; leaves valid high
   task automatic write_register(input logic index, input int value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data <= 16'(value);
      do @(posedge clock); while (!csr_ch.ready);
      if (index == pfba_pkg::CSR_LOW_BASE) begin
         arena_base_sh = value & 16'h7fff;
         low_hint_sh = arena_base_sh;
      end else begin
         arena_limit_sh = value & 16'hffff;
         high_hint_sh = arena_limit_sh;
      end
   endtask

   function automatic logic [26:0] page_address(input int lo, input int hi);
      int p;
      p = $urandom_range(lo, hi);
      return 27'((p << pfba_pkg::PAGE_SHIFT) | $urandom_range(0, 4095));
   endfunction

   // random request biased towards the arenas in use
   task automatic random_request(input int area_pages_max);
      int r;
      int lo;
      int hi;
      logic [2:0] op;
      logic [26:0] address;
      logic [27:0] size;
      r = $urandom_range(0, 99);
      if (r < 24) op = pfba_pkg::OP_ALLOC_LOW;
      else if (r < 38) op = pfba_pkg::OP_ALLOC_HIGH;
      else if (r < 53) op = pfba_pkg::OP_ALLOC_AREA;
      else if (r < 80) op = pfba_pkg::OP_FREE;
      else if (r < 89) op = pfba_pkg::OP_MARK_FREE;
      else if (r < 97) op = pfba_pkg::OP_MARK_USED;
      else op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
      lo = (arena_base_sh > 8) ? arena_base_sh - 8 : 0;
      hi = arena_limit_sh + 300;
      if (hi > pfba_pkg::NUM_PAGES - 1) hi = pfba_pkg::NUM_PAGES - 1;
      if (lo > hi) lo = 0;
      if ($urandom_range(0, 99) < 85) address = page_address(lo, hi);
      else address = 27'($urandom);
      r = $urandom_range(0, 99);
      if (r < 2) size = 28'($urandom_range(0, 28'hfffffff));
      else if (r < 3) size = 28'h8000000 | 28'($urandom);
      else if (r < 85) size = 28'(($urandom_range(0, 8) << pfba_pkg::PAGE_SHIFT) |
                                  $urandom_range(0, 4095));
      else size = 28'(($urandom_range(0, area_pages_max) << pfba_pkg::PAGE_SHIFT) |
                      $urandom_range(0, 4095));
      send_request(op, address, size);
   endtask

   localparam int DIR_ROWS = 21;
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      // everything used after reset: allocations fail
      '{pfba_pkg::OP_ALLOC_LOW,  27'h0,       28'h0,       1'b1, pfba_pkg::ST_NO_SPACE, 27'h0},
      '{pfba_pkg::OP_ALLOC_HIGH, 27'h0,       28'h0,       1'b1, pfba_pkg::ST_NO_SPACE, 27'h0},
      // zero-page area requests
      '{pfba_pkg::OP_ALLOC_AREA, 27'h0,       28'h0,       1'b1, pfba_pkg::ST_NO_SPACE, 27'h0},
      '{pfba_pkg::OP_ALLOC_AREA, 27'h0,       28'hfff,     1'b1, pfba_pkg::ST_NO_SPACE, 27'h0},
      '{pfba_pkg::OP_MARK_FREE,  27'h100000,  28'h40000,   1'b1, pfba_pkg::ST_OK,       27'h0},
      // top page freed and reallocated from the high arena
      '{pfba_pkg::OP_FREE,       27'h7ffffff, 28'h0,       1'b1, pfba_pkg::ST_OK,       27'h0},
      '{pfba_pkg::OP_ALLOC_HIGH, 27'h0,       28'h0,       1'b0, pfba_pkg::ST_OK,       27'h0},
      '{pfba_pkg::OP_ALLOC_LOW,  27'h0,       28'h0,       1'b1, pfba_pkg::ST_NO_SPACE, 27'h0},
      '{pfba_pkg::OP_FREE,       27'h100000,  28'h0,       1'b1, pfba_pkg::ST_OK,       27'h0},
      '{pfba_pkg::OP_ALLOC_LOW,  27'h0,       28'h0,       1'b0, pfba_pkg::ST_OK,       27'h0},
      '{pfba_pkg::OP_ALLOC_AREA, 27'h0,       28'h8000,    1'b0, pfba_pkg::ST_OK,       27'h0},
      '{pfba_pkg::OP_ALLOC_AREA, 27'h0,       28'hfffffff, 1'b1, pfba_pkg::ST_NO_SPACE, 27'h0},
      // range running past the last page
      '{pfba_pkg::OP_MARK_USED,  27'h7fff000, 28'hfffffff, 1'b1, pfba_pkg::ST_RANGE,    27'h0},
      '{pfba_pkg::OP_MARK_FREE,  27'h7ffffff, 28'h1000,    1'b1, pfba_pkg::ST_OK,       27'h0},
      // free below the arena base pulls the hint down
      '{pfba_pkg::OP_FREE,       27'h10000,   28'h0,       1'b1, pfba_pkg::ST_OK,       27'h0},
      '{pfba_pkg::OP_ALLOC_LOW,  27'h0,       28'h0,       1'b0, pfba_pkg::ST_OK,       27'h0},
      '{OP_SPARE_6,              27'h7ffffff, 28'hfffffff, 1'b1, pfba_pkg::ST_OK,       27'h0},
      '{OP_SPARE_7,              27'h0,       28'h8000000, 1'b1, pfba_pkg::ST_OK,       27'h0},
      '{pfba_pkg::OP_MARK_USED,  27'h0,       28'h0,       1'b1, pfba_pkg::ST_OK,       27'h0},
      // area run not starting at the hint
      '{pfba_pkg::OP_ALLOC_AREA, 27'h0,       28'h3000,    1'b0, pfba_pkg::ST_OK,       27'h0},
      '{pfba_pkg::OP_ALLOC_LOW,  27'h0,       28'h0,       1'b0, pfba_pkg::ST_OK,       27'h0}
   };

   // stimulus
   initial begin
      int base;
      int limit;
      int count;
      alloc_result_type fixed_res;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.op <= pfba_pkg::OP_ALLOC_LOW;
      req_ch.address <= '0;
      req_ch.size_bytes <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= pfba_pkg::CSR_LOW_BASE;
      csr_ch.data <= '0;
      foreach (page_used_sh[i]) page_used_sh[i] = 1'b1;
      arena_base_sh = 256;
      arena_limit_sh = 4096;
      low_hint_sh = 256;
      high_hint_sh = 4096;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      for (int i = 0; i < DIR_ROWS; i++) begin
         fixed_res.status = DIRECTED[i].status;
         fixed_res.addr = DIRECTED[i].raddr;
         send_request(DIRECTED[i].op, DIRECTED[i].address, DIRECTED[i].size,
                      DIRECTED[i].fixed, fixed_res);
         sender_gap(pick_gap());
      end

      // random phases, each under its own arena setting
      for (int ph = 0; ph < 8; ph++) begin
         wait_for_drain();
         case (ph)
            0: begin base = 32767; limit = 1; end
            1: begin base = 0; limit = 32768; end
            default: begin
               base = $urandom_range(0, 31000);
               limit = base + $urandom_range(32, 800);
            end
         endcase
         write_register(pfba_pkg::CSR_LOW_BASE, base);
         write_register(pfba_pkg::CSR_LOW_LIMIT, limit);
         csr_ch.valid <= 1'b0;
         // open a free window over the arena start and the high arena start
         send_request(pfba_pkg::OP_MARK_FREE, 27'(base << pfba_pkg::PAGE_SHIFT),
                      28'(((ph == 1) ? 512 : 64) << pfba_pkg::PAGE_SHIFT));
         send_request(pfba_pkg::OP_MARK_FREE,
                      27'((limit & 16'h7fff) << pfba_pkg::PAGE_SHIFT),
                      28'(256 << pfba_pkg::PAGE_SHIFT));
         count = (ph < 2) ? 60 : 270;
         for (int n = 0; n < count; n++) begin
            if (ph == 2 && n == 40) hold_off_request = 1'b1;
            if (ph == 3 && n == 100) wait_for_drain();
            random_request((ph == 1) ? 16 : 64);
            sender_gap(($urandom_range(0, 3) == 0) ? 0 : pick_gap());
         end
      end

      // drain and finish
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("** page_frame_bitmap_allocator: PASSED **");
      end else begin
         $display("** page_frame_bitmap_allocator: FAILED **");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/pfba_pkg.sv
design/pfba_if.sv
design/pfba_ram.sv
design/pfba_dp.sv
design/pfba_ctrl.sv
design/page_frame_bitmap_allocator.sv
tb/sv/tb_page_frame_bitmap_allocator.sv
